// ===== hdl/ipt_pkg.sv =====
// package: item types, register codes and trim clamp for the injector pulse trimmer
`timescale 1ns / 1ps

package ipt_pkg;

  // channel count and field widths
  localparam int CHANNELS  = 4;
  localparam int CHAN_W    = 2;
  localparam int GATE_W    = 4;
  localparam int TIME_W    = 32;
  localparam int TRIM_W    = 13;
  localparam int LIMIT_W   = 12;
  localparam int FRAC_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  // smallest clamped trim magnitude that switches intercept on
  localparam int LATCH_MIN = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;

  // register reset values
  localparam logic [TRIM_W-1:0]  TRIM_RESET  = 13'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd614;

  // item kinds
  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef logic signed [TRIM_W-1:0] trim_t;

  typedef struct packed {
    logic              func;
    logic [CHAN_W-1:0] channel;
    logic              sense_level;
    logic [TIME_W-1:0] now_us;
  } item_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_levels;
    logic [GATE_W-1:0] gate_changed;
    logic [TIME_W-1:0] trimmed_width_us;
    logic              intercept_on;
  } result_t;

  // requested trim clamped to plus or minus the limit
  function automatic trim_t eff_trim(input trim_t trim, input logic [LIMIT_W-1:0] limit);
    logic signed [TRIM_W:0] t;
    logic signed [TRIM_W:0] l;
    t = {trim[TRIM_W-1], trim};
    l = {2'b00, limit};
    if (t > l) begin
      t = l;
    end else if (t < -l) begin
      t = -l;
    end
    return t[TRIM_W-1:0];
  endfunction

  // magnitude large enough to latch intercept mode
  function automatic logic trim_latches(input trim_t t);
    return (t >= trim_t'(LATCH_MIN)) || (t <= -trim_t'(LATCH_MIN));
  endfunction

endpackage

// ===== hdl/ipt_scale.sv =====
// width scaler: measured width times (1 + trim), truncated and saturated
`timescale 1ns / 1ps

module ipt_scale (
  input  logic [ipt_pkg::TIME_W-1:0] start_us,
  input  logic [ipt_pkg::TIME_W-1:0] now_us,
  input  ipt_pkg::trim_t             trim,
  output logic [ipt_pkg::TIME_W-1:0] trimmed_us
);
  import ipt_pkg::*;

  localparam int PROD_W = TIME_W + TRIM_W;

  logic [TIME_W-1:0]       width_us;
  logic [TRIM_W:0]         factor_wide;
  logic [TRIM_W-1:0]       factor;
  logic [PROD_W-1:0]       product;
  logic [PROD_W-FRAC_W-1:0] shifted;

  // measured width, wraps with the timestamp
  assign width_us = now_us - start_us;

  // factor 4096 + t stays within 1 .. 8191 since t is at least -4095
  assign factor_wide = (TRIM_W + 1)'(1 << FRAC_W) + {trim[TRIM_W-1], trim};
  assign factor      = factor_wide[TRIM_W-1:0];

  // scale, drop the fraction, saturate to the timestamp width
  assign product = PROD_W'(width_us) * PROD_W'(factor);
  assign shifted = product[PROD_W-1:FRAC_W];
  assign trimmed_us = shifted[TIME_W] ? {TIME_W{1'b1}} : shifted[TIME_W-1:0];

endmodule

// ===== hdl/injector_pulse_trim_top.sv =====
// top level: registers, channel state and result register of the injector pulse trimmer
`timescale 1ns / 1ps

// Four-channel injector pulse regenerator. Each item is a sense edge or a time
// tick and yields exactly one result. One item is taken every clock unless the
// output stalls: all the work (width measurement, one 32 x 13 multiply, four
// parallel end-of-pulse compares) sits between the accepted item and the result
// register, so the result is valid in the cycle after acceptance and the input
// stalls only while a result is held by a stalled output. Registers are trim_q
// (index 0) and trim_limit_q (index 1); writes are always ready, and intercept
// mode latches on for good when the clamped trim reaches a magnitude of 5/4096.

module injector_pulse_trim_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ipt_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ipt_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ipt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ipt_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ipt_pkg::*;

  // configuration and mode
  trim_t               trim_q;
  logic [LIMIT_W-1:0]  trim_limit_q;
  logic                intercept_latch;

  // channel state
  logic [TIME_W-1:0]   pulse_start [CHANNELS];
  logic [TIME_W-1:0]   target_width [CHANNELS];
  logic [CHANNELS-1:0] pulse_active;
  logic [CHANNELS-1:0] ecu_pulse_ended;
  logic [GATE_W-1:0]   gate_state;

  logic [CHANNELS-1:0] pulse_active_next;
  logic [CHANNELS-1:0] ecu_pulse_ended_next;
  logic [GATE_W-1:0]   gate_state_next;
  logic [GATE_W-1:0]   changed;
  logic [TIME_W-1:0]   trimmed;
  logic                start_we;
  logic                target_we;

  trim_t               t_cur;
  trim_t               t_new;
  logic [TIME_W-1:0]   scaled_us;
  logic                accept;
  logic                cfg_we;

  // handshakes
  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // effective trim now and after the write being taken
  assign t_cur = eff_trim(trim_q, trim_limit_q);

  always_comb begin
    t_new = t_cur;
    unique case (cfg_index)
      REG_TRIM:  t_new = eff_trim(cfg_data[TRIM_W-1:0], trim_limit_q);
      REG_LIMIT: t_new = eff_trim(trim_q, cfg_data[LIMIT_W-1:0]);
      default:   t_new = t_cur;
    endcase
  end

  // register writes and intercept latch
  always_ff @(posedge clk) begin
    if (rst) begin
      trim_q          <= TRIM_RESET;
      trim_limit_q    <= LIMIT_RESET;
      intercept_latch <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIM:  trim_q <= cfg_data[TRIM_W-1:0];
        REG_LIMIT: trim_limit_q <= cfg_data[LIMIT_W-1:0];
        default:   ;
      endcase
      if ((cfg_index == REG_TRIM || cfg_index == REG_LIMIT) && trim_latches(t_new)) begin
        intercept_latch <= 1'b1;
      end
    end
  end

  // trimmed width for the edge channel
  ipt_scale u_scale (
    .start_us   (pulse_start[item.channel]),
    .now_us     (item.now_us),
    .trim       (t_cur),
    .trimmed_us (scaled_us)
  );

  // next channel state and result for the offered item
  always_comb begin
    pulse_active_next    = pulse_active;
    ecu_pulse_ended_next = ecu_pulse_ended;
    gate_state_next      = gate_state;
    changed              = '0;
    trimmed              = '0;
    start_we             = 1'b0;
    target_we            = 1'b0;
    if (item.func == FUNC_EDGE) begin
      if (int'(item.channel) < CHANNELS) begin
        if (!intercept_latch) begin
          // pass-through: gate follows the inverted sense line
          gate_state_next[item.channel] = !item.sense_level;
          changed[item.channel]         = 1'b1;
        end else if (!item.sense_level) begin
          // ecu opens: start a pulse
          start_we                           = 1'b1;
          pulse_active_next[item.channel]    = 1'b1;
          ecu_pulse_ended_next[item.channel] = 1'b0;
          gate_state_next[item.channel]      = 1'b1;
          changed[item.channel]              = 1'b1;
        end else if (pulse_active[item.channel]) begin
          // ecu closes: record trimmed width, close now or extend
          trimmed   = scaled_us;
          target_we = 1'b1;
          if (t_cur <= trim_t'(0)) begin
            gate_state_next[item.channel]   = 1'b0;
            changed[item.channel]           = 1'b1;
            pulse_active_next[item.channel] = 1'b0;
          end else begin
            ecu_pulse_ended_next[item.channel] = 1'b1;
          end
        end
      end
    end else if (intercept_latch && t_cur > trim_t'(0)) begin
      // tick: close every extended pulse whose trimmed width has run out
      for (int i = 0; i < CHANNELS; i++) begin
        if (pulse_active[i] && ecu_pulse_ended[i] &&
            (item.now_us - pulse_start[i]) >= target_width[i]) begin
          gate_state_next[i]      = 1'b0;
          changed[i]              = 1'b1;
          pulse_active_next[i]    = 1'b0;
          ecu_pulse_ended_next[i] = 1'b0;
        end
      end
    end
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_active    <= '0;
      ecu_pulse_ended <= '0;
      gate_state      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_start[i]  <= '0;
        target_width[i] <= '0;
      end
    end else if (accept) begin
      pulse_active    <= pulse_active_next;
      ecu_pulse_ended <= ecu_pulse_ended_next;
      gate_state      <= gate_state_next;
      if (start_we) begin
        pulse_start[item.channel] <= item.now_us;
      end
      if (target_we) begin
        target_width[item.channel] <= trimmed;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.gate_levels      <= gate_state_next;
      result.gate_changed     <= changed;
      result.trimmed_width_us <= trimmed;
      result.intercept_on     <= intercept_latch;
    end
  end

endmodule

// ===== tb/tb_injector_pulse_trim_top.sv =====
// testbench: injector pulse trimmer against an in-bench predictor of gates, widths and intercept
`timescale 1ns / 1ps

module tb_injector_pulse_trim_top;
  import ipt_pkg::*;

  // register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int REPORT_MAX  = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // predicted block state and register copies
  trim_t             want_trim = TRIM_RESET;
  logic [LIMIT_W-1:0] want_limit = LIMIT_RESET;
  logic              want_intercept = 1'b0;
  logic [GATE_W-1:0] want_gates = '0;
  logic [TIME_W-1:0] want_start [CHANNELS];
  logic [TIME_W-1:0] want_target [CHANNELS];
  logic              want_active [CHANNELS];
  logic              want_ended [CHANNELS];

  // items waiting to go out, results still owed by the block
  item_t   pending [$];
  result_t results_due [$];
  int      items_queued = 0;
  int      items_taken = 0;
  int      mismatches = 0;

  // pacing of both sides
  int   gap_max = 9;
  int   rx_max = 9;
  int   send_wait = 0;
  int   rx_wait = 0;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   quiet = 0;

  // stimulus generator state
  logic [TIME_W-1:0] clock_us = '0;
  logic              pulse_open [CHANNELS];

  injector_pulse_trim_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      want_start[i] = '0;
      want_target[i] = '0;
      want_active[i] = 1'b0;
      want_ended[i] = 1'b0;
      pulse_open[i] = 1'b0;
    end
  end

  // requested trim clamped to the limit
  function automatic int clamped_trim();
    int t;
    int lim;
    t = want_trim;
    lim = want_limit;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t;
  endfunction

  // width scaled by one plus trim, truncated and saturated
  function automatic logic [TIME_W-1:0] stretch_width(input logic [TIME_W-1:0] w, input int t);
    logic [63:0] gain;
    logic [63:0] p;
    gain = 64'(4096 + t);
    p = {32'd0, w} * gain;
    p = p >> FRAC_W;
    if (p[63:32] != 0) return '1;
    return p[TIME_W-1:0];
  endfunction

  // register copy update, intercept latches on a large enough clamped trim
  function automatic void note_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] data);
    int  t;
    logic known;
    known = 1'b1;
    if (idx == REG_TRIM) begin
      want_trim = trim_t'(data);
    end else if (idx == REG_LIMIT) begin
      want_limit = data[LIMIT_W-1:0];
    end else begin
      known = 1'b0;
    end
    t = clamped_trim();
    if (known && (t >= LATCH_MIN || t <= -LATCH_MIN)) want_intercept = 1'b1;
  endfunction

  // expected gates, width and intercept flag for one accepted item
  task automatic predict_gates(input item_t it);
    result_t           r;
    int                t;
    int                ch;
    logic [GATE_W-1:0] ch_mask;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    t = clamped_trim();
    if (it.func == FUNC_EDGE) begin
      ch = it.channel;
      ch_mask = GATE_W'(1) << ch;
      if (!want_intercept) begin
        // pass-through: gate follows the inverted sense line
        if (it.sense_level) want_gates &= ~ch_mask;
        else want_gates |= ch_mask;
        r.gate_changed |= ch_mask;
      end else if (!it.sense_level) begin
        want_start[ch] = it.now_us;
        want_active[ch] = 1'b1;
        want_ended[ch] = 1'b0;
        want_gates |= ch_mask;
        r.gate_changed |= ch_mask;
      end else if (want_active[ch]) begin
        elapsed = it.now_us - want_start[ch];
        r.trimmed_width_us = stretch_width(elapsed, t);
        want_target[ch] = r.trimmed_width_us;
        if (t <= 0) begin
          want_gates &= ~ch_mask;
          r.gate_changed |= ch_mask;
          want_active[ch] = 1'b0;
        end else begin
          want_ended[ch] = 1'b1;
        end
      end
    end else if (want_intercept && t > 0) begin
      // tick: close every extended pulse whose trimmed width has run out
      for (int i = 0; i < CHANNELS; i++) begin
        elapsed = it.now_us - want_start[i];
        if (want_active[i] && want_ended[i] && elapsed >= want_target[i]) begin
          ch_mask = GATE_W'(1) << i;
          want_gates &= ~ch_mask;
          r.gate_changed |= ch_mask;
          want_active[i] = 1'b0;
          want_ended[i] = 1'b0;
        end
      end
    end
    r.gate_levels = want_gates;
    r.intercept_on = want_intercept;
    results_due.push_back(r);
  endtask

  // item sender
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_wait = 0;
    end else if (!(item_valid && item_stall)) begin
      if (item_valid) begin
        predict_gates(item);
        items_taken++;
      end
      if (send_wait > 0) begin
        send_wait--;
        item_valid <= 1'b0;
      end else if (pending.size() != 0) begin
        item <= pending.pop_front();
        item_valid <= 1'b1;
        send_wait = $urandom_range(0, gap_max);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result receiver and checker
  always @(posedge clk) begin : rx_side
    result_t due;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: gates %h changed %h width %h intercept %b",
                     result.gate_levels, result.gate_changed,
                     result.trimmed_width_us, result.intercept_on);
        end else begin
          due = results_due.pop_front();
          if (result.gate_levels !== due.gate_levels ||
              result.gate_changed !== due.gate_changed ||
              result.trimmed_width_us !== due.trimmed_width_us ||
              result.intercept_on !== due.intercept_on) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("mismatch (exp/got): gates %h/%h changed %h/%h width %h/%h on %b/%b",
                       due.gate_levels, result.gate_levels,
                       due.gate_changed, result.gate_changed,
                       due.trimmed_width_us, result.trimmed_width_us,
                       due.intercept_on, result.intercept_on);
          end
        end
        rx_wait = $urandom_range(0, rx_max);
      end
      // long hold-off on request, otherwise the per-item stall
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic queue_item(input logic func, input logic [CHAN_W-1:0] ch,
                            input logic lvl, input logic [TIME_W-1:0] now);
    item_t it;
    it.func = func;
    it.channel = ch;
    it.sense_level = lvl;
    it.now_us = now;
    pending.push_back(it);
    items_queued++;
  endtask

  // mostly well-formed open/close pairs and ticks, the rest noise
  task automatic queue_traffic(input int count);
    int roll;
    int ch;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      clock_us += $urandom_range(0, 300);
      if (roll < 25) begin
        queue_item(1'($urandom), 2'($urandom), 1'($urandom),
                   (roll < 8) ? $urandom : clock_us);
      end else if (roll < 50) begin
        queue_item(FUNC_TICK, 2'($urandom), 1'($urandom), clock_us);
      end else begin
        ch = $urandom_range(0, CHANNELS - 1);
        queue_item(FUNC_EDGE, CHAN_W'(ch), pulse_open[ch], clock_us);
        pulse_open[ch] = !pulse_open[ch];
      end
    end
  endtask

  // every queued item taken and every result back
  task automatic wait_idle();
    while (items_taken != items_queued || results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    note_reg_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // limit first so that pass-through settings never pass through a large trim
  task automatic set_trim(input logic [TRIM_W-1:0] trim, input logic [LIMIT_W-1:0] limit);
    write_reg(REG_LIMIT, {1'($urandom), limit});
    write_reg(REG_TRIM, trim);
  endtask

  task automatic traffic_phase(input logic [TRIM_W-1:0] trim, input logic [LIMIT_W-1:0] limit,
                               input logic idling, input int count);
    set_trim(trim, limit);
    gap_max = idling ? 9 : 0;
    rx_max = idling ? 9 : 0;
    queue_traffic(count);
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through: gates mirror the inverted sense line, ticks ignored
    queue_item(FUNC_EDGE, 0, 1'b0, 32'h0000_0000);
    queue_item(FUNC_EDGE, 1, 1'b0, 32'hFFFF_FFFF);
    queue_item(FUNC_EDGE, 2, 1'b0, 32'h0000_0010);
    queue_item(FUNC_EDGE, 3, 1'b0, 32'h0000_0020);
    queue_item(FUNC_EDGE, 2, 1'b1, 32'h0000_0030);
    queue_item(FUNC_TICK, 3, 1'b1, 32'h0000_0040);
    queue_item(FUNC_EDGE, 0, 1'b1, 32'h0000_0050);
    queue_item(FUNC_EDGE, 3, 1'b1, 32'h0000_0060);
    queue_traffic(40);
    wait_idle();

    // spare register indexes are ignored
    write_reg(REG_SPARE_A, CFG_DAT_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DAT_W'($urandom));

    // trims clamped below the latch threshold keep pass-through
    traffic_phase(-13'sd4, 12'd4095, 1'b1, 40);
    traffic_phase(13'h1000, 12'd0, 1'b1, 40);
    traffic_phase(13'h0FFF, 12'd0, 1'b0, 40);
    traffic_phase(13'h0FFF, 12'd4, 1'b1, 40);

    // largest positive trim latches intercept
    set_trim(13'h0FFF, 12'd4095);
    gap_max = 9;
    rx_max = 9;
    // width across the timestamp wrap, tick too early then in time
    queue_item(FUNC_EDGE, 0, 1'b0, 32'hFFFF_FFF0);
    queue_item(FUNC_EDGE, 0, 1'b1, 32'h0000_0010);
    queue_item(FUNC_TICK, 0, 1'b0, 32'h0000_0020);
    queue_item(FUNC_TICK, 0, 1'b0, 32'h0000_0040);
    // high edge with no pulse open
    queue_item(FUNC_EDGE, 1, 1'b1, 32'h0000_0005);
    // saturated width
    queue_item(FUNC_EDGE, 1, 1'b0, 32'h0000_0000);
    queue_item(FUNC_EDGE, 1, 1'b1, 32'hFFFF_FFFF);
    queue_item(FUNC_TICK, 2, 1'b1, 32'hFFFF_FFFF);
    // two channels closed by one tick
    queue_item(FUNC_EDGE, 2, 1'b0, 32'd100);
    queue_item(FUNC_EDGE, 3, 1'b0, 32'd100);
    queue_item(FUNC_EDGE, 2, 1'b1, 32'd200);
    queue_item(FUNC_EDGE, 3, 1'b1, 32'd300);
    queue_item(FUNC_TICK, 1, 1'b0, 32'd1000);
    // extended pulse left open across a change to negative trim
    queue_item(FUNC_EDGE, 0, 1'b0, 32'd50);
    queue_item(FUNC_EDGE, 0, 1'b1, 32'd60);
    wait_idle();
    set_trim(13'h1000, 12'd4095);
    queue_item(FUNC_TICK, 0, 1'b0, 32'd100000);
    queue_item(FUNC_EDGE, 0, 1'b1, 32'd5000);
    wait_idle();

    // random traffic over a spread of trim settings
    traffic_phase(13'h1000, 12'd4095, 1'b1, 148);
    traffic_phase(13'd5, 12'd614, 1'b0, 148);
    traffic_phase(13'($urandom_range(5, 4095)), 12'($urandom), 1'b1, 148);
    traffic_phase(13'd0, 12'd614, 1'b1, 148);
    traffic_phase(13'($urandom), 12'd0, 1'b0, 148);
    clock_us = 32'hFFFF_F000;
    traffic_phase(13'h0FFF, 12'd4095, 1'b1, 148);
    traffic_phase(-13'sd5, 12'd614, 1'b1, 148);
    traffic_phase(13'($urandom), 12'($urandom), 1'b1, 148);

    // receiver holds off while the sender keeps offering
    set_trim(13'd614, 12'd614);
    gap_max = 0;
    rx_max = 0;
    hold_toggle <= ~hold_toggle;
    queue_traffic(148);
    wait_idle();

    repeat (5) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
